// ----- rtl/lsfq_pkg.sv -----
`timescale 1ns / 1ps
package lsfq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_DATA_WIDTH  = 32;

	localparam int WORD_W     = 32;
	localparam int IN_TDATA_W = ((WORD_W + 7) / 8) * 8;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam int OUT_DROP_BIT  = 0;
	localparam int OUT_VALID_BIT = 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_NEXT = 4'b0010,
		ST_READ = 4'b0100,
		ST_OUT  = 4'b1000
	} lsfq_state_t;

endpackage

// ----- rtl/lsfq_ram.sv -----
`timescale 1ns / 1ps
module lsfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/lsfq_free_enc.sv -----
`timescale 1ns / 1ps
module lsfq_free_enc #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic [DEPTH-1:0] used,
	output logic             found,
	output logic [AW-1:0]    idx
);

	always_comb begin
		idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!used[i]) begin
				idx = AW'(i);
			end
		end
	end

	assign found = ~&used;

endmodule

// ----- rtl/linked_slot_fifo_queue_top.sv -----
`timescale 1ns / 1ps
// An accepted item takes the sequencer from ST_IDLE to ST_READ, or via ST_NEXT for a
// delete whose head has a successor (one extra link-memory read); ST_OUT then loads the
// output register and raises m_tvalid once the output is free. No new item is taken until
// ST_IDLE, after the registered link and payload memory reads and any m_tready stall.
// Reset (arst_n low, asynchronous) clears the state, slot valid bits, head, tail, count and
// m_tvalid; the memories are not swept, so items are taken right away.
module linked_slot_fifo_queue_top
	import lsfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // data_word
	input  logic                  s_tuser,  // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// head_word, entry_count, zero fill
	output logic [((WORD_W + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	output logic [1:0]            m_tuser   // add_dropped, head_valid
);

	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_TDATA_W = ((WORD_W + CNT_W + 7) / 8) * 8;

	lsfq_state_t             state_q;
	logic [QUEUE_DEPTH-1:0]  used_q;
	logic [IDX_W-1:0]        head_q;
	logic [IDX_W-1:0]        tail_q;
	logic [CNT_W-1:0]        len_q;
	logic                    drop_q;
	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic [1:0]              m_tuser_q;

	logic                    free_found;
	logic [IDX_W-1:0]        free_idx;

	logic                    accept;
	logic                    do_add;
	logic                    do_del;
	logic                    pay_we;
	logic                    pay_re;
	logic [DATA_WIDTH-1:0]   pay_wdata;
	logic [DATA_WIDTH-1:0]   pay_rdata;
	logic                    nxt_we;
	logic                    nxt_re;
	logic [IDX_W-1:0]        nxt_rdata;
	logic [DATA_WIDTH+WORD_W-1:0] in_ext;
	logic [DATA_WIDTH+WORD_W-1:0] out_ext;
	logic [WORD_W-1:0]       head_word;
	logic                    out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign do_add   = accept && (s_tuser == CMD_ADD)
		&& (len_q != CNT_W'(QUEUE_DEPTH)) && free_found;
	assign do_del   = accept && (s_tuser == CMD_DELETE) && (len_q != '0);

	assign in_ext    = {{DATA_WIDTH{1'b0}}, s_tdata[WORD_W-1:0]};
	assign pay_wdata = in_ext[DATA_WIDTH-1:0];
	assign pay_we    = do_add;
	assign pay_re    = (state_q == ST_READ);
	assign nxt_we    = do_add && (len_q != '0);
	assign nxt_re    = do_del && (len_q != CNT_W'(1));

	assign out_ext   = {{WORD_W{1'b0}}, pay_rdata};
	assign head_word = (len_q != '0) ? out_ext[WORD_W-1:0] : '0;
	assign out_free  = !m_tvalid_q || m_tready;

	lsfq_free_enc #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (IDX_W)
	) u_free_enc (
		.used  (used_q),
		.found (free_found),
		.idx   (free_idx)
	);

	lsfq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (QUEUE_DEPTH),
		.AW    (IDX_W)
	) u_payload_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (free_idx),
		.wdata (pay_wdata),
		.re    (pay_re),
		.raddr (head_q),
		.rdata (pay_rdata)
	);

	lsfq_ram #(
		.WIDTH (IDX_W),
		.DEPTH (QUEUE_DEPTH),
		.AW    (IDX_W)
	) u_link_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (tail_q),
		.wdata (free_idx),
		.re    (nxt_re),
		.raddr (head_q),
		.rdata (nxt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			len_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= nxt_re ? ST_NEXT : ST_READ;
						if (do_add) begin
							used_q[free_idx] <= 1'b1;
							tail_q           <= free_idx;
							len_q            <= len_q + CNT_W'(1);
							if (len_q == '0) begin
								head_q <= free_idx;
							end
						end
						if (do_del) begin
							used_q[head_q] <= 1'b0;
							len_q          <= len_q - CNT_W'(1);
							if (len_q == CNT_W'(1)) begin
								head_q <= '0;
								tail_q <= '0;
							end
						end
					end
				end
				ST_NEXT: begin
					head_q  <= nxt_rdata;
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drop_q <= (s_tuser == CMD_ADD) && !do_add;
		end
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata_q <= OUT_TDATA_W'({len_q, head_word});
			m_tuser_q <= {(len_q != '0), drop_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above depth");

	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(len_q))
		else $error("used slots disagree with entry count");

	a_empty_home: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0) && (state_q == ST_IDLE) |-> (head_q == '0) && (tail_q == '0))
		else $error("empty queue with head or tail away from slot zero");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("sequencer returned to idle right after accepting");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_free |=> m_tvalid_q)
		else $error("result not presented after output stage");
`endif

endmodule
